[sv/bmmd_pkg.sv]
// Shared types and constants for the banked memory map decoder.
package bmmd_pkg;

    // Region codes reported with every access
    typedef logic [3:0] t_region;
    localparam t_region RGN_BOOT   = 4'd0;
    localparam t_region RGN_ROM    = 4'd1;
    localparam t_region RGN_VRAM   = 4'd2;
    localparam t_region RGN_ERAM   = 4'd3;
    localparam t_region RGN_WRAM   = 4'd4;
    localparam t_region RGN_OAM    = 4'd5;
    localparam t_region RGN_ZERO   = 4'd6;
    localparam t_region RGN_HRAM   = 4'd7;
    localparam t_region RGN_IE     = 4'd8;
    localparam t_region RGN_IF     = 4'd9;
    localparam t_region RGN_VIDEO  = 4'd10;
    localparam t_region RGN_TIMER  = 4'd11;
    localparam t_region RGN_JOYPAD = 4'd12;

    // Cartridge kinds
    typedef logic [1:0] t_cart_kind;
    localparam t_cart_kind CART_NONE     = 2'd0;
    localparam t_cart_kind CART_MBC1     = 2'd1;
    localparam t_cart_kind CART_MBC1_RAM = 2'd2;
    localparam t_cart_kind CART_MBC1_BAT = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CART_KIND = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOT_DONE = 1'd1;

    // Controller write windows, selected by address bits 14:13
    localparam logic [1:0] CTL_RAM_EN   = 2'd0;
    localparam logic [1:0] CTL_ROM_LO   = 2'd1;
    localparam logic [1:0] CTL_BANK_HI  = 2'd2;
    localparam logic [1:0] CTL_BANK_MOD = 2'd3;

    localparam logic [3:0] RAM_EN_KEY = 4'hA;
    localparam int OFFSET_W = 21;

endpackage

[sv/banked_memory_map_decoder.sv]
// Top level: bank controller registers and one-stage bus address decode.
//
// Each bus request (read or write) yields one result: region code, byte offset,
// stored flag and the RAM enable flag after the request. One request per cycle
// is taken unless stalled, and its result is in the output register next cycle;
// the input is stalled only while that register holds a result the consumer
// stalls. Controller writes (below 0x8000) update the bank registers in the same
// cycle, and the decode of that request already sees the updated banks. The RAM
// enable flag is reported but never gates an access.
module banked_memory_map_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [bmmd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bmmd_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    // request channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_mode,
    input  logic [15:0]                         i_address,
    input  logic [7:0]                          i_data,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [3:0]                          o_region,
    output logic [bmmd_pkg::OFFSET_W-1:0]       o_offset,
    output logic                                o_stored,
    output logic                                o_ram_enabled
);

    // configuration and controller state
    bmmd_pkg::t_cart_kind r_cart_kind;
    logic                 r_boot_done;
    logic [6:0]           r_rom_bank, n_rom_bank;
    logic [1:0]           r_ram_bank, n_ram_bank;
    logic                 r_bank_mode, n_bank_mode;
    logic                 r_ram_en, n_ram_en;

    // result register
    logic                          r_out_valid;
    bmmd_pkg::t_region             r_region, n_region;
    logic [bmmd_pkg::OFFSET_W-1:0] r_offset, n_offset;
    logic                          r_stored;
    logic                          r_ram_enabled;

    logic w_accept;
    logic w_ctl_wr;
    logic w_any_mbc;
    logic w_has_ram;
    logic [7:0] w_low;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_ctl_wr   = w_accept && i_mode && !i_address[15];
    assign w_any_mbc  = (r_cart_kind != bmmd_pkg::CART_NONE);
    assign w_has_ram  = (r_cart_kind == bmmd_pkg::CART_MBC1_RAM) ||
                        (r_cart_kind == bmmd_pkg::CART_MBC1_BAT);
    assign w_low      = i_address[7:0];

    // next bank controller state from a controller write
    always_comb begin
        n_rom_bank  = r_rom_bank;
        n_ram_bank  = r_ram_bank;
        n_bank_mode = r_bank_mode;
        n_ram_en    = r_ram_en;
        if (w_ctl_wr) begin
            unique case (i_address[14:13])
                bmmd_pkg::CTL_RAM_EN: begin
                    if (w_has_ram) n_ram_en = (i_data[3:0] == bmmd_pkg::RAM_EN_KEY);
                end
                bmmd_pkg::CTL_ROM_LO: begin
                    if (w_any_mbc) begin
                        // bank 0 in the low bits reads as bank 1
                        n_rom_bank[4:0] = (i_data[4:0] == 5'd0) ? 5'd1 : i_data[4:0];
                    end
                end
                bmmd_pkg::CTL_BANK_HI: begin
                    if (w_any_mbc) begin
                        if (r_bank_mode) n_ram_bank = i_data[1:0];
                        else             n_rom_bank[6:5] = i_data[1:0];
                    end
                end
                bmmd_pkg::CTL_BANK_MOD: begin
                    if (w_has_ram) n_bank_mode = i_data[0];
                end
                default: ;
            endcase
        end
    end

    // address decode using the updated banks
    always_comb begin
        n_region = bmmd_pkg::RGN_ZERO;
        n_offset = '0;
        if (i_address[15:14] == 2'b00) begin
            n_region = (!r_boot_done && i_address[15:8] == 8'h00) ?
                       bmmd_pkg::RGN_BOOT : bmmd_pkg::RGN_ROM;
            n_offset = {5'd0, i_address};
        end else if (i_address[15:14] == 2'b01) begin
            n_region = bmmd_pkg::RGN_ROM;
            n_offset = {n_rom_bank, i_address[13:0]};
        end else if (i_address[15:13] == 3'b100) begin
            n_region = bmmd_pkg::RGN_VRAM;
            n_offset = {8'd0, i_address[12:0]};
        end else if (i_address[15:13] == 3'b101) begin
            n_region = bmmd_pkg::RGN_ERAM;
            n_offset = {6'd0, n_ram_bank, i_address[12:0]};
        end else if (i_address < 16'hFE00) begin
            n_region = bmmd_pkg::RGN_WRAM;
            n_offset = {8'd0, i_address[12:0]};
        end else if (i_address[15:8] == 8'hFE) begin
            if (i_address < 16'hFEA0) begin
                n_region = bmmd_pkg::RGN_OAM;
                n_offset = {13'd0, w_low};
            end
        end else if (i_address == 16'hFFFF) begin
            n_region = bmmd_pkg::RGN_IE;
        end else if (w_low[7]) begin
            n_region = bmmd_pkg::RGN_HRAM;
            n_offset = {14'd0, w_low[6:0]};
        end else if (w_low[5:4] != 2'b00) begin
            n_region = bmmd_pkg::RGN_ZERO;
        end else if (w_low[6]) begin
            n_region = bmmd_pkg::RGN_VIDEO;
            n_offset = {17'd0, w_low[3:0]};
        end else if (w_low[3:0] == 4'h0) begin
            n_region = bmmd_pkg::RGN_JOYPAD;
        end else if (w_low[3:2] == 2'b01) begin
            n_region = bmmd_pkg::RGN_TIMER;
            n_offset = {19'd0, w_low[1:0]};
        end else if (w_low[3:0] == 4'hF) begin
            n_region = bmmd_pkg::RGN_IF;
        end
    end

    // configuration and controller registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cart_kind <= bmmd_pkg::CART_NONE;
            r_boot_done <= 1'b0;
            r_rom_bank  <= 7'd1;
            r_ram_bank  <= 2'd0;
            r_bank_mode <= 1'b0;
            r_ram_en    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    bmmd_pkg::CFG_CART_KIND: r_cart_kind <= i_cfg_data;
                    bmmd_pkg::CFG_BOOT_DONE: r_boot_done <= i_cfg_data[0];
                    default: ;
                endcase
            end
            r_rom_bank  <= n_rom_bank;
            r_ram_bank  <= n_ram_bank;
            r_bank_mode <= n_bank_mode;
            r_ram_en    <= n_ram_en;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_region      <= n_region;
            r_offset      <= n_offset;
            r_stored      <= i_mode && i_address[15];
            r_ram_enabled <= n_ram_en;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_region      = r_region;
    assign o_offset      = r_offset;
    assign o_stored      = r_stored;
    assign o_ram_enabled = r_ram_enabled;

    // the low ROM bank bits never hold zero
    a_rom_bank_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rom_bank[4:0] != 5'd0)
        else $error("ROM bank low bits are zero");

    // a read leaves the bank controller untouched
    a_read_no_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_mode) |=> ($stable(r_rom_bank) && $stable(r_ram_bank) &&
                                   $stable(r_bank_mode) && $stable(r_ram_en)))
        else $error("read changed controller state");

    // without a controller nothing changes the banks
    a_no_mbc_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cart_kind == bmmd_pkg::CART_NONE) |=> ($stable(r_rom_bank) &&
            $stable(r_ram_bank) && $stable(r_bank_mode) && $stable(r_ram_en)))
        else $error("bank state changed without controller");

    // a stored write never decodes into ROM or boot space
    a_stored_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_stored) |-> (o_region != bmmd_pkg::RGN_ROM &&
                                       o_region != bmmd_pkg::RGN_BOOT))
        else $error("stored write in ROM region");

endmodule
